// ----- hw/rtl/double_ended_queue_with_search_top_macros.svh -----
// Assertion helpers shared by the deque top level.
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define DEQS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define DEQS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

// ----- hw/rtl/deqs_pkg.sv -----
package deqs_pkg;

  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_BACK   = 3'd3;
  localparam logic [2:0] MODE_CONTAINS   = 3'd4;
  localparam logic [2:0] MODE_CLEAR      = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_CONTAINS,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
    logic               found;
    logic [4:0]         count;
  } out_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] value;
  } cmd_t;

endpackage

// ----- hw/rtl/deqs_front.sv -----
module deqs_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  deqs_pkg::in_t   in_data,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output deqs_pkg::cmd_t  cmd_data
);

  logic           valid_r;
  logic           valid_nxt;
  deqs_pkg::cmd_t cmd_r;
  deqs_pkg::cmd_t cmd_nxt;
  logic           accept;

  assign in_stall  = valid_r && !cmd_ready;
  assign accept    = in_valid && !in_stall;
  assign cmd_valid = valid_r;
  assign cmd_data  = cmd_r;

  always_comb begin
    cmd_nxt   = cmd_r;
    valid_nxt = valid_r;
    if (valid_r && cmd_ready) begin
      valid_nxt = 1'b0;
    end
    if (accept) begin
      valid_nxt     = 1'b1;
      cmd_nxt.value = in_data.value;
      unique case (in_data.mode)
        deqs_pkg::MODE_PUSH_FRONT: cmd_nxt.op = deqs_pkg::OP_PUSH_FRONT;
        deqs_pkg::MODE_PUSH_BACK:  cmd_nxt.op = deqs_pkg::OP_PUSH_BACK;
        deqs_pkg::MODE_POP_FRONT:  cmd_nxt.op = deqs_pkg::OP_POP_FRONT;
        deqs_pkg::MODE_POP_BACK:   cmd_nxt.op = deqs_pkg::OP_POP_BACK;
        deqs_pkg::MODE_CONTAINS:   cmd_nxt.op = deqs_pkg::OP_CONTAINS;
        deqs_pkg::MODE_CLEAR:      cmd_nxt.op = deqs_pkg::OP_CLEAR;
        default:                   cmd_nxt.op = deqs_pkg::OP_NOP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule

// ----- hw/rtl/deqs_cmdq.sv -----
module deqs_cmdq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  deqs_pkg::cmd_t  push_data,
  output logic            pop_valid,
  input  logic            pop,
  output deqs_pkg::cmd_t  pop_data
);

  deqs_pkg::cmd_t slot_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     fill_r;
  logic           do_push;
  logic           do_pop;

  assign push_ready = fill_r != 2'd2;
  assign pop_valid  = fill_r != 2'd0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/deqs_back.sv -----
module deqs_back #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  output logic            cmd_pop,
  input  deqs_pkg::cmd_t  cmd_data,
  output logic            out_valid,
  input  logic            out_stall,
  output deqs_pkg::out_t  out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  typedef enum logic [1:0] {S_IDLE, S_POP, S_SCAN, S_DONE} state_t;

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           front_r, front_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [DATA_WIDTH-1:0]   word_r, word_nxt;
  logic [CW-1:0]           scan_i_r, scan_i_nxt;
  logic [CW-1:0]           cmp_i_r, cmp_i_nxt;
  logic                    cmp_vld_r, cmp_vld_nxt;
  deqs_pkg::out_t          res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  deqs_pkg::out_t          out_r, out_nxt;

  logic [DATA_WIDTH-1:0]   store [DEPTH];
  logic [DATA_WIDTH-1:0]   rdata_r;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;

  logic [DATA_WIDTH-1:0]   word_in;
  logic signed [63:0]      rdata_ext;
  logic                    full;
  logic                    empty;

  // Sum of an index and an offset, both below twice the depth, folded back.
  function automatic logic [AW-1:0] wrap_idx(input logic [CW:0] s);
    return (s >= DEPTH_S) ? AW'(s - DEPTH_S) : AW'(s);
  endfunction

  assign word_in   = DATA_WIDTH'({32'd0, cmd_data.value});
  assign rdata_ext = 64'($signed(rdata_r));
  assign full      = count_r == DEPTH_C;
  assign empty     = count_r == '0;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    word_nxt      = word_r;
    scan_i_nxt    = scan_i_r;
    cmp_i_nxt     = cmp_i_r;
    cmp_vld_nxt   = 1'b0;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    cmd_pop       = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = front_r;
    rd_en         = 1'b0;
    rd_addr       = front_r;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          res_nxt   = '0;
          state_nxt = S_DONE;
          unique case (cmd_data.op)
            deqs_pkg::OP_PUSH_FRONT: begin
              if (full) begin
                res_nxt.status = deqs_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = (front_r == '0) ? LAST_IDX : front_r - AW'(1);
                front_nxt = wr_addr;
                count_nxt = count_r + CW'(1);
              end
            end
            deqs_pkg::OP_PUSH_BACK: begin
              if (full) begin
                res_nxt.status = deqs_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = wrap_idx((CW + 1)'(front_r) + (CW + 1)'(count_r));
                count_nxt = count_r + CW'(1);
              end
            end
            deqs_pkg::OP_POP_FRONT: begin
              if (empty) begin
                res_nxt.status = deqs_pkg::ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = front_r;
                front_nxt = wrap_idx((CW + 1)'(front_r) + (CW + 1)'(1));
                count_nxt = count_r - CW'(1);
                state_nxt = S_POP;
              end
            end
            deqs_pkg::OP_POP_BACK: begin
              if (empty) begin
                res_nxt.status = deqs_pkg::ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = wrap_idx((CW + 1)'(front_r) + (CW + 1)'(count_r - CW'(1)));
                count_nxt = count_r - CW'(1);
                state_nxt = S_POP;
              end
            end
            deqs_pkg::OP_CONTAINS: begin
              word_nxt = word_in;
              if (!empty) begin
                scan_i_nxt = '0;
                cmp_i_nxt  = '0;
                state_nxt  = S_SCAN;
              end
            end
            deqs_pkg::OP_CLEAR: begin
              front_nxt = '0;
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        res_nxt.data = rdata_ext[31:0];
        state_nxt    = S_DONE;
      end
      S_SCAN: begin
        // Reads are issued one entry ahead of the compare, which sees the
        // registered read data in the following cycle.
        rd_addr = wrap_idx((CW + 1)'(front_r) + (CW + 1)'(scan_i_r));
        if (scan_i_r < count_r) begin
          rd_en       = 1'b1;
          scan_i_nxt  = scan_i_r + CW'(1);
          cmp_vld_nxt = 1'b1;
        end
        if (cmp_vld_r) begin
          if (rdata_r == word_r) begin
            res_nxt.found = 1'b1;
            state_nxt     = S_DONE;
          end else if (cmp_i_r == count_r - CW'(1)) begin
            state_nxt = S_DONE;
          end else begin
            cmp_i_nxt = cmp_i_r + CW'(1);
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          out_nxt.count = 5'(count_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    word_r   <= word_nxt;
    scan_i_r <= scan_i_nxt;
    cmp_i_r  <= cmp_i_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= word_in;
    end
    if (rd_en) begin
      rdata_r <= store[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/double_ended_queue_with_search_top.sv -----
// Commands pass through the input register, the command queue and the executor. Push, clear,
// unused modes and contains on an empty queue go straight to the result; pops first read the
// store, and contains compares held entries one by one through the single store read port,
// stopping at the first match or the last entry. The executor takes a new command only after
// its result has been handed to the output register, so commands wait in the queue meanwhile.
// Reset clears pointers, count and handshake state; the entry store keeps its contents.
`include "double_ended_queue_with_search_top_macros.svh"

module double_ended_queue_with_search_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  deqs_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output deqs_pkg::out_t  out_data
);

  logic           fq_valid;
  logic           fq_ready;
  deqs_pkg::cmd_t fq_data;
  logic           qb_valid;
  logic           qb_pop;
  deqs_pkg::cmd_t qb_data;
  logic           res_full;
  logic           res_empty;
  logic           res_hit;

  deqs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd_data  (fq_data)
  );

  deqs_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop        (qb_pop),
    .pop_data   (qb_data)
  );

  deqs_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (qb_valid),
    .cmd_pop   (qb_pop),
    .cmd_data  (qb_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign res_full  = out_valid && out_data.status == deqs_pkg::ST_FULL;
  assign res_empty = out_valid && out_data.status == deqs_pkg::ST_EMPTY;
  assign res_hit   = out_valid && out_data.found;

  // A dropped push can only be reported with the store full.
  `DEQS_ASSERT_NOW(a_full_count, res_full, out_data.count == 5'(DEPTH))
  // A pop from an empty queue leaves it empty and returns zero.
  `DEQS_ASSERT_NOW(a_empty_pop, res_empty, out_data.count == 5'd0 && out_data.data == 32'sd0)
  // A hit needs at least one held entry and a clean status.
  `DEQS_ASSERT_NOW(a_found_ok, res_hit, out_data.status == deqs_pkg::ST_OK && out_data.count != 5'd0)
  // The executor never pops the command queue while it is empty.
  `DEQS_ASSERT_NOW(a_pop_valid, qb_pop, qb_valid)

endmodule
